FILE: src/gia_pkg.sv
// Package for the Gaussian integer ALU: request and result types, codes and helpers.
`default_nettype none
package gia_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_BITS = 64;

	typedef enum logic [2:0] {
		K_ADD  = 3'd0,
		K_SUB  = 3'd1,
		K_NEG  = 3'd2,
		K_MUL  = 3'd3,
		K_DIV  = 3'd4,
		K_CONJ = 3'd5,
		K_NORM = 3'd6,
		K_EQ   = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVF     = 2'd1,
		ST_DIV0    = 2'd2,
		ST_INEXACT = 2'd3
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] a_real;
		logic signed [31:0] a_imag;
		logic signed [31:0] b_real;
		logic signed [31:0] b_imag;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_real;
		logic signed [31:0] result_imag;
		logic [62:0]        norm_value;
		logic               is_equal;
		status_t            status;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t              kind;
		status_t            st;
		logic signed [31:0] ar;
		logic signed [31:0] ai;
		logic signed [31:0] br;
		logic signed [31:0] bi;
	} cmd_t;

	localparam logic [31:0] PART_BAD_LO = 32'h8000_0000;
	localparam logic [31:0] PART_BAD_HI = 32'h7fff_ffff;
	localparam logic signed [65:0] PART_MIN_W = -66'sd2147483647;
	localparam logic signed [65:0] PART_MAX_W = 66'sd2147483646;

	function automatic logic part_bad(logic [31:0] v);
		return (v == PART_BAD_LO) || (v == PART_BAD_HI);
	endfunction

	function automatic logic in_range(logic signed [65:0] v);
		return (v >= PART_MIN_W) && (v <= PART_MAX_W);
	endfunction

endpackage
`default_nettype wire

FILE: src/gia_front.sv
// Front end: takes requests, checks operands and flags zero divisors.
`default_nettype none
module gia_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  gia_pkg::req_t   request,
	output logic            busy,
	input  wire             push_ready,
	output logic            push_valid,
	output gia_pkg::cmd_t   push_data
);
	import gia_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t cmd_c;
	logic uses_b;
	logic accept;

	assign busy = vld_s1 && !push_ready;
	assign accept = start && !busy;

	always_comb begin
		uses_b = (request.kind inside {K_ADD, K_SUB, K_MUL, K_DIV, K_EQ});
		cmd_c.kind = request.kind;
		cmd_c.ar = request.a_real;
		cmd_c.ai = request.a_imag;
		cmd_c.br = request.b_real;
		cmd_c.bi = request.b_imag;
		if (part_bad(request.a_real) || part_bad(request.a_imag) ||
				(uses_b && (part_bad(request.b_real) || part_bad(request.b_imag)))) begin
			cmd_c.st = ST_OVF;
		end else if (request.kind == K_DIV && request.b_real == '0 &&
				request.b_imag == '0) begin
			cmd_c.st = ST_DIV0;
		end else begin
			cmd_c.st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !push_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_c;
		end
	end

	assign push_valid = vld_s1;
	assign push_data = cmd_s1;
endmodule
`default_nettype wire

FILE: src/gia_queue.sv
// Small request queue between front and back.
`default_nettype none
module gia_queue #(
	parameter int Depth = gia_pkg::QUEUE_DEPTH
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  gia_pkg::cmd_t   push_data,
	output logic            full,
	input  wire             pop,
	output logic            empty,
	output gia_pkg::cmd_t   pop_data
);
	import gia_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	cmd_t mem_q [Depth];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(Depth));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

FILE: src/gia_back.sv
// Back end: products, sums, pipelined exact divider and result checks.
`default_nettype none
module gia_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  gia_pkg::cmd_t   in_cmd,
	output logic            pop,
	output logic            done,
	output gia_pkg::rsp_t   result
);
	import gia_pkg::*;

	typedef struct packed {
		kind_t              kind;
		status_t            st;
		logic signed [31:0] ar;
		logic signed [31:0] ai;
		logic signed [31:0] br;
		logic signed [31:0] bi;
		logic signed [63:0] p_rr;
		logic signed [63:0] p_ii;
		logic signed [63:0] p_ri;
		logic signed [63:0] p_ir;
		logic signed [63:0] p_aa;
		logic signed [63:0] p_bb;
		logic signed [63:0] p_nr;
		logic signed [63:0] p_ni;
	} prod_t;

	typedef struct packed {
		kind_t              kind;
		status_t            st;
		logic signed [65:0] wr;
		logic signed [65:0] wi;
		logic [62:0]        norm;
		logic               eq;
		logic [62:0]        n;
		logic               negr;
		logic               negi;
		logic [62:0]        remr;
		logic [63:0]        accr;
		logic [62:0]        remi;
		logic [63:0]        acci;
	} dv_t;

	function automatic dv_t div_step(dv_t d);
		dv_t                o;
		logic [63:0]        tr;
		logic [63:0]        ti;
		logic               gr;
		logic               gi;
		o = d;
		tr = {d.remr, d.accr[63]};
		ti = {d.remi, d.acci[63]};
		gr = (tr >= {1'b0, d.n});
		gi = (ti >= {1'b0, d.n});
		o.remr = gr ? 63'(tr - {1'b0, d.n}) : tr[62:0];
		o.remi = gi ? 63'(ti - {1'b0, d.n}) : ti[62:0];
		o.accr = {d.accr[62:0], gr};
		o.acci = {d.acci[62:0], gi};
		return o;
	endfunction

	logic  vld_s1;
	prod_t prod_s1;
	logic  [DIV_BITS:0] vld_div_s;
	dv_t   div_s [DIV_BITS+1];
	dv_t   s2_c;
	logic signed [64:0] pr;
	logic signed [64:0] pi;
	logic signed [64:0] pr_abs;
	logic signed [64:0] pi_abs;
	logic signed [65:0] fr;
	logic signed [65:0] fi;
	status_t fst;
	rsp_t  rsp_c;
	dv_t   dl;

	assign pop = in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_div_s <= '0;
			done <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_div_s <= {vld_div_s[DIV_BITS-1:0], vld_s1};
			done <= vld_div_s[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1.kind <= in_cmd.kind;
		prod_s1.st <= in_cmd.st;
		prod_s1.ar <= in_cmd.ar;
		prod_s1.ai <= in_cmd.ai;
		prod_s1.br <= in_cmd.br;
		prod_s1.bi <= in_cmd.bi;
		prod_s1.p_rr <= in_cmd.ar * in_cmd.br;
		prod_s1.p_ii <= in_cmd.ai * in_cmd.bi;
		prod_s1.p_ri <= in_cmd.ar * in_cmd.bi;
		prod_s1.p_ir <= in_cmd.ai * in_cmd.br;
		prod_s1.p_aa <= in_cmd.ar * in_cmd.ar;
		prod_s1.p_bb <= in_cmd.ai * in_cmd.ai;
		prod_s1.p_nr <= in_cmd.br * in_cmd.br;
		prod_s1.p_ni <= in_cmd.bi * in_cmd.bi;
	end

	always_comb begin
		pr = 65'(prod_s1.p_rr) + 65'(prod_s1.p_ii);
		pi = 65'(prod_s1.p_ir) - 65'(prod_s1.p_ri);
		pr_abs = pr[64] ? -pr : pr;
		pi_abs = pi[64] ? -pi : pi;
		s2_c.kind = prod_s1.kind;
		s2_c.st = prod_s1.st;
		s2_c.norm = '0;
		s2_c.eq = 1'b0;
		s2_c.n = 63'(prod_s1.p_nr[62:0] + prod_s1.p_ni[62:0]);
		s2_c.negr = pr[64];
		s2_c.negi = pi[64];
		s2_c.remr = '0;
		s2_c.remi = '0;
		s2_c.accr = pr_abs[63:0];
		s2_c.acci = pi_abs[63:0];
		s2_c.wr = '0;
		s2_c.wi = '0;
		case (prod_s1.kind)
			K_ADD: begin
				s2_c.wr = 66'(prod_s1.ar) + 66'(prod_s1.br);
				s2_c.wi = 66'(prod_s1.ai) + 66'(prod_s1.bi);
			end
			K_SUB: begin
				s2_c.wr = 66'(prod_s1.ar) - 66'(prod_s1.br);
				s2_c.wi = 66'(prod_s1.ai) - 66'(prod_s1.bi);
			end
			K_NEG: begin
				s2_c.wr = -66'(prod_s1.ar);
				s2_c.wi = -66'(prod_s1.ai);
			end
			K_MUL: begin
				s2_c.wr = 66'(prod_s1.p_rr) - 66'(prod_s1.p_ii);
				s2_c.wi = 66'(prod_s1.p_ri) + 66'(prod_s1.p_ir);
			end
			K_CONJ: begin
				s2_c.wr = 66'(prod_s1.ar);
				s2_c.wi = -66'(prod_s1.ai);
			end
			K_NORM: begin
				s2_c.norm = 63'(prod_s1.p_aa[62:0] + prod_s1.p_bb[62:0]);
			end
			K_EQ: begin
				s2_c.eq = (prod_s1.ar == prod_s1.br) && (prod_s1.ai == prod_s1.bi);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		div_s[0] <= s2_c;
	end

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
		always_ff @(posedge clk) begin
			div_s[i+1] <= div_step(div_s[i]);
		end
	end

	always_comb begin
		dl = div_s[DIV_BITS];
		fst = dl.st;
		fr = dl.wr;
		fi = dl.wi;
		if (dl.kind == K_DIV) begin
			fr = dl.negr ? -{2'b00, dl.accr} : {2'b00, dl.accr};
			fi = dl.negi ? -{2'b00, dl.acci} : {2'b00, dl.acci};
			if (fst == ST_OK && (dl.remr != '0 || dl.remi != '0)) begin
				fst = ST_INEXACT;
			end
		end
		if (fst == ST_OK && (!in_range(fr) || !in_range(fi))) begin
			fst = ST_OVF;
		end
		rsp_c.status = fst;
		if (fst == ST_OK) begin
			rsp_c.result_real = fr[31:0];
			rsp_c.result_imag = fi[31:0];
			rsp_c.norm_value = dl.norm;
			rsp_c.is_equal = dl.eq;
		end else begin
			rsp_c.result_real = '0;
			rsp_c.result_imag = '0;
			rsp_c.norm_value = '0;
			rsp_c.is_equal = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		result <= rsp_c;
	end
endmodule
`default_nettype wire

FILE: src/gaussian_integer_alu_unit.sv
// Top level of the Gaussian integer ALU: front end, queue and back end.
// A request is taken on any clock edge with start high and busy low, one per
// cycle. Each request gives exactly one result, shown on result for a single
// cycle with done high, in request order. The divider is a 64-stage pipeline
// retiring one quotient bit per stage for both parts at once. The back end
// drains its queue every cycle, so busy stays low in normal use; the receiver
// cannot stall.
`default_nettype none
module gaussian_integer_alu_unit #(
	parameter int QueueDepth = gia_pkg::QUEUE_DEPTH
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  gia_pkg::req_t   request,
	output logic            done,
	output gia_pkg::rsp_t   result
);
	import gia_pkg::*;

	localparam int LAT = DIV_BITS + 5;

	logic q_full;
	logic q_empty;
	logic push_valid;
	logic pop;
	cmd_t push_data;
	cmd_t pop_data;

	gia_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.busy       (busy),
		.push_ready (!q_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	gia_queue #(.Depth(QueueDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	gia_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.in_cmd   (pop_data),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

	a_no_backup: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue backed up");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing at expected latency");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.result_real == '0 &&
		result.result_imag == '0 && result.norm_value == '0 && !result.is_equal))
		else $error("error result carries data");
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the Gaussian integer ALU: random and directed requests checked against a predictor.
`timescale 1ns / 100ps
module tb;
	import gia_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;

	gaussian_integer_alu_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int idle_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;
	logic stim_done = 1'b0;

	function automatic logic part_legal(longint v);
		return v >= -64'sd2147483647 && v <= 64'sd2147483646;
	endfunction

	function automatic rsp_t gauss_compute(req_t r);
		rsp_t o;
		longint ar, ai, br, bi, rr, ri, n, pr, pi;
		logic uses_b;
		status_t st;
		logic [63:0] nv;
		o = '0;
		ar = longint'(r.a_real);
		ai = longint'(r.a_imag);
		br = longint'(r.b_real);
		bi = longint'(r.b_imag);
		rr = 0;
		ri = 0;
		nv = '0;
		st = ST_OK;
		uses_b = r.kind inside {K_ADD, K_SUB, K_MUL, K_DIV, K_EQ};
		if (!part_legal(ar) || !part_legal(ai) ||
				(uses_b && (!part_legal(br) || !part_legal(bi)))) begin
			st = ST_OVF;
		end else begin
			case (r.kind)
				K_ADD: begin rr = ar + br; ri = ai + bi; end
				K_SUB: begin rr = ar - br; ri = ai - bi; end
				K_NEG: begin rr = -ar; ri = -ai; end
				K_MUL: begin rr = ar * br - ai * bi; ri = ar * bi + ai * br; end
				K_DIV: begin
					if (br == 0 && bi == 0) begin
						st = ST_DIV0;
					end else begin
						n = br * br + bi * bi;
						pr = ar * br + ai * bi;
						pi = ai * br - ar * bi;
						if (pr % n != 0 || pi % n != 0) st = ST_INEXACT;
						else begin rr = pr / n; ri = pi / n; end
					end
				end
				K_CONJ: begin rr = ar; ri = -ai; end
				K_NORM: nv = 64'(ar * ar) + 64'(ai * ai);
				default: o.is_equal = (ar == br && ai == bi);
			endcase
			if (st == ST_OK && (!part_legal(rr) || !part_legal(ri))) st = ST_OVF;
		end
		if (st != ST_OK) begin
			o = '0;
		end else begin
			o.result_real = rr[31:0];
			o.result_imag = ri[31:0];
			o.norm_value = nv[62:0];
		end
		o.status = st;
		return o;
	endfunction

	always @(negedge clk) begin
		if (arst_n && !busy && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
			request <= pending_reqs.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (start && !busy) begin
			expected_rsps = {expected_rsps, gauss_compute(request)};
		end
		if (done) begin
			if (expected_rsps.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (result.result_real !== exp_r.result_real) begin
					$error("result_real exp %0d got %0d", exp_r.result_real, result.result_real);
					errors++;
				end
				if (result.result_imag !== exp_r.result_imag) begin
					$error("result_imag exp %0d got %0d", exp_r.result_imag, result.result_imag);
					errors++;
				end
				if (result.norm_value !== exp_r.norm_value) begin
					$error("norm_value exp %0d got %0d", exp_r.norm_value, result.norm_value);
					errors++;
				end
				if (result.is_equal !== exp_r.is_equal) begin
					$error("is_equal exp %0b got %0b", exp_r.is_equal, result.is_equal);
					errors++;
				end
				if (result.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, result.status);
					errors++;
				end
			end
		end
		if (quiet_cycles > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rand_part(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(200)) - 100);
			2: return 32'($signed($urandom_range(200000)) - 100000);
			default: begin
				case ($urandom_range(5))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h8000_0001;
					3: return 32'h7fff_fffe;
					4: return 32'h0;
					default: return 32'hffff_ffff;
				endcase
			end
		endcase
	endfunction

	task automatic add_req(kind_t k, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi);
		req_t r;
		r.kind = k;
		r.a_real = ar;
		r.a_imag = ai;
		r.b_real = br;
		r.b_imag = bi;
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic drain_phase();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start) @(posedge clk);
	endtask

	initial begin
		req_t r;
		kind_t k;
		int m;
		logic [31:0] qr, qi, dr, di;
		longint pr, pi;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// edge values, each kind
		for (int i = 0; i < 8; i++) begin
			k = kind_t'(i);
			add_req(k, 32'h7fff_fffe, 32'h8000_0001, 32'h7fff_fffe, 32'h8000_0001);
			add_req(k, 32'h8000_0000, 32'd3, 32'h7fff_ffff, 32'd1);
		end
		add_req(K_DIV, 32'd5, 32'd7, 32'd0, 32'd0);
		add_req(K_DIV, 32'd5, 32'd7, 32'd2, 32'd1);
		add_req(K_DIV, 32'd3, 32'd4, 32'd2, 32'd1);
		add_req(K_NEG, 32'h8000_0001, 32'd0, 32'd0, 32'd0);
		add_req(K_EQ, 32'd9, 32'hffff_fff0, 32'd9, 32'hffff_fff0);
		add_req(K_NORM, 32'h8000_0001, 32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff);
		add_req(K_SUB, 32'h8000_0001, 32'd0, 32'd1, 32'd0);
		drain_phase();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 3) ? 21 : 88;
			for (int n = 0; n < 150; n++) begin
				m = $urandom_range(9);
				r.kind = kind_t'($urandom_range(7));
				r.a_real = rand_part(m % 4);
				r.a_imag = rand_part(m % 4);
				r.b_real = rand_part((m + $urandom_range(1)) % 4);
				r.b_imag = rand_part(m % 4);
				if (r.kind == K_DIV && $urandom_range(1)) begin
					qr = rand_part(1);
					qi = rand_part(1);
					dr = rand_part(2);
					di = rand_part(2);
					pr = longint'($signed(qr)) * longint'($signed(dr))
						- longint'($signed(qi)) * longint'($signed(di));
					pi = longint'($signed(qr)) * longint'($signed(di))
						+ longint'($signed(qi)) * longint'($signed(dr));
					r.a_real = pr[31:0];
					r.a_imag = pi[31:0];
					r.b_real = dr;
					r.b_imag = di;
				end else if (r.kind == K_EQ && $urandom_range(1)) begin
					r.b_real = r.a_real;
					r.b_imag = r.a_imag;
				end
				pending_reqs = {pending_reqs, r};
			end
			drain_phase();
		end
		stim_done = 1'b1;
		repeat (100) @(posedge clk);
		if (expected_rsps.size() != 0 || pending_reqs.size() != 0) begin
			$error("requests left without results: %0d", expected_rsps.size());
			errors++;
		end
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
